@@ sv/csrp_pkg.sv @@
// ----------------------------------------------------------------------------
// csrp_pkg
// Shared types, constants and byte packing for the clock register planner.
// ----------------------------------------------------------------------------
package csrp_pkg;

  localparam logic [29:0] VCO_MAX_HZ    = 30'd900000000;
  localparam logic [19:0] FRAC_DEN      = 20'd1048575;
  localparam logic [27:0] F_MIN_HZ      = 28'd1000000;
  localparam logic [27:0] F_MAX_HZ      = 28'd225000000;
  localparam logic [25:0] XTAL_MIN_HZ   = 26'd10000000;
  localparam logic [25:0] XTAL_MAX_HZ   = 26'd40000000;
  localparam logic [7:0]  PLL_RESET_CMD = 8'hA0;
  localparam logic [7:0]  CLK_ON_PLLA   = 8'h4F;
  localparam logic [17:0] P1_OFFSET     = 18'd512;

  // Index of the last pipeline register
  localparam int PIPE_LAST = 40;

  // Configuration register indexes
  localparam logic [2:0] REG_CRYSTAL   = 3'd0;
  localparam logic [2:0] REG_PLL_BASE  = 3'd1;
  localparam logic [2:0] REG_SYN0_BASE = 3'd2;
  localparam logic [2:0] REG_SYN1_BASE = 3'd3;
  localparam logic [2:0] REG_SYN2_BASE = 3'd4;
  localparam logic [2:0] REG_PLL_RST   = 3'd5;
  localparam logic [2:0] REG_CTRL_BASE = 3'd6;
  localparam logic [2:0] REG_OUT_DIV   = 3'd7;

  localparam logic [1:0] CH_PLL_ONLY = 2'd3;

  // Pipeline word; each stage updates the fields it owns.
  typedef struct packed {
    logic [27:0] f;
    logic [25:0] xtal;
    logic [1:0]  ch;
    logic        clamp;
    logic [9:0]  dv;
    logic [45:0] rem;
    logic [6:0]  mq;
    logic [19:0] nq;
    logic [17:0] p1;
    logic [19:0] p2;
  } pl_t;

  typedef struct packed {
    logic [17:0] p1;
    logic [19:0] p2;
    logic [17:0] dp1;
    logic [1:0]  ch;
    logic        clamp;
  } item_t;

  typedef struct packed {
    logic [7:0] pll_base;
    logic [7:0] syn0_base;
    logic [7:0] syn1_base;
    logic [7:0] syn2_base;
    logic [7:0] pll_rst;
    logic [7:0] ctrl_base;
    logic [6:0] out_div;
  } cfg_t;

  // One byte of an eight-byte parameter block.
  function automatic logic [7:0] pack_byte(input logic [2:0] sel, input logic [17:0] p1,
                                           input logic [19:0] p2, input logic [19:0] p3);
    logic [7:0] b;
    begin
      unique case (sel)
        3'd0: b = p3[15:8];
        3'd1: b = p3[7:0];
        3'd2: b = {6'd0, p1[17:16]};
        3'd3: b = p1[15:8];
        3'd4: b = p1[7:0];
        3'd5: b = {p3[19:16], p2[19:16]};
        3'd6: b = p2[15:8];
        default: b = p2[7:0];
      endcase
      return b;
    end
  endfunction

endpackage

@@ sv/csrp_emit.sv @@
// ----------------------------------------------------------------------------
// csrp_emit
// Holds one computed item and plays it out as register write transfers.
// ----------------------------------------------------------------------------
module csrp_emit (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_vld,
  input  csrp_pkg::item_t  item,
  output logic             item_take,
  input  csrp_pkg::cfg_t   cfg,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       reg_addr,
  output logic [7:0]       wr_data,
  output logic             last_write,
  output logic             clamped
);
  import csrp_pkg::*;

  item_t      hold;
  logic       busy;
  logic [4:0] idx;
  logic [4:0] idx_last;
  logic       slot_free;
  logic       emit;
  logic       is_last;
  logic [7:0] sbase;
  logic [7:0] e_addr;
  logic [7:0] e_data;

  assign idx_last  = (hold.ch == CH_PLL_ONLY) ? 5'd7 : 5'd17;
  assign is_last   = (idx == idx_last);
  assign slot_free = !out_valid || !out_stall;
  assign emit      = busy && slot_free;
  assign item_take = !busy || (emit && is_last);

  always_comb begin
    unique case (hold.ch)
      2'd0:    sbase = cfg.syn0_base;
      2'd1:    sbase = cfg.syn1_base;
      default: sbase = cfg.syn2_base;
    endcase
  end

  always_comb begin
    if (idx < 5'd8) begin
      e_addr = cfg.pll_base + {5'd0, idx[2:0]};
      e_data = pack_byte(idx[2:0], hold.p1, hold.p2, FRAC_DEN);
    end else if (idx < 5'd16) begin
      e_addr = sbase + {5'd0, idx[2:0]};
      e_data = pack_byte(idx[2:0], hold.dp1, 20'd0, 20'd1);
      if (idx[2:0] == 3'd2) begin
        e_data = e_data | {1'b0, cfg.out_div};
      end
    end else if (idx == 5'd16) begin
      e_addr = cfg.pll_rst;
      e_data = PLL_RESET_CMD;
    end else begin
      e_addr = cfg.ctrl_base + {6'd0, hold.ch};
      e_data = CLK_ON_PLLA;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= 5'd0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (slot_free) begin
        out_valid <= 1'b0;
      end
      // A new item is loaded when idle, or replaces the one whose last write just went out.
      if (item_vld && item_take) begin
        busy <= 1'b1;
        idx  <= 5'd0;
      end else if (emit) begin
        idx <= idx + 5'd1;
        if (is_last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      reg_addr   <= e_addr;
      wr_data    <= e_data;
      last_write <= is_last;
      clamped    <= hold.clamp;
    end
    if (item_vld && item_take) begin
      hold <= item;
    end
  end

endmodule

@@ sv/clock_synth_register_planner.sv @@
// ----------------------------------------------------------------------------
// clock_synth_register_planner
// Turns a frequency request into the register writes for a PLL synthesizer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid/in_stall carry target_hz and channel. A request
//   is taken on an edge with in_valid high and in_stall low.
//   Output channel: out_valid/out_stall carry one register write transfer
//   (reg_addr, wr_data, last_write, clamped) per accepted edge.
//   A request for outputs 0..2 yields 18 transfers, channel 3 yields 8;
//   last_write marks the final transfer of each run.
//   The three dividers resolve one quotient bit per stage (37 stages).
//   Throughput: the pipeline takes one request per cycle while in_stall
//   is low; the write player sets the sustained rate at one transfer per
//   cycle while out_stall is low.
//   Reset (rst, synchronous) empties the pipeline and the output register
//   and loads the configuration defaults.
//   When the receiver stalls, the current transfer holds; the pipeline keeps
//   filling until a finished request waits at its end, then in_stall rises.
//   Write configuration through cfg_we/cfg_index/cfg_data only while idle.
// ----------------------------------------------------------------------------
module clock_synth_register_planner (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [27:0] target_hz,
  input  logic [1:0]  channel,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [25:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  reg_addr,
  output logic [7:0]  wr_data,
  output logic        last_write,
  output logic        clamped
);
  import csrp_pkg::*;

  logic [25:0] crystal_hz;
  cfg_t        cfg;

  pl_t   pipe [0:PIPE_LAST];
  logic  vld  [0:PIPE_LAST];
  logic  en;
  logic  item_take;
  item_t item;
  pl_t   s_in;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      crystal_hz    <= 26'd25000000;
      cfg.pll_base  <= 8'd26;
      cfg.syn0_base <= 8'd42;
      cfg.syn1_base <= 8'd50;
      cfg.syn2_base <= 8'd58;
      cfg.pll_rst   <= 8'd177;
      cfg.ctrl_base <= 8'd16;
      cfg.out_div   <= 7'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CRYSTAL:   crystal_hz    <= cfg_data;
        REG_PLL_BASE:  cfg.pll_base  <= cfg_data[7:0];
        REG_SYN0_BASE: cfg.syn0_base <= cfg_data[7:0];
        REG_SYN1_BASE: cfg.syn1_base <= cfg_data[7:0];
        REG_SYN2_BASE: cfg.syn2_base <= cfg_data[7:0];
        REG_PLL_RST:   cfg.pll_rst   <= cfg_data[7:0];
        REG_CTRL_BASE: cfg.ctrl_base <= cfg_data[7:0];
        REG_OUT_DIV:   cfg.out_div   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Advance the whole pipe unless a finished request waits at its end.
  assign en       = !(vld[PIPE_LAST] && !item_take);
  assign in_stall = !en;

  // Entry stage: clamp frequency and crystal, seed the first dividend.
  always_comb begin
    s_in       = '0;
    s_in.f     = target_hz;
    s_in.ch    = channel;
    s_in.clamp = 1'b0;
    if (target_hz < F_MIN_HZ) begin
      s_in.f     = F_MIN_HZ;
      s_in.clamp = 1'b1;
    end
    if (target_hz > F_MAX_HZ) begin
      s_in.f     = F_MAX_HZ;
      s_in.clamp = 1'b1;
    end
    s_in.xtal = crystal_hz;
    if (crystal_hz < XTAL_MIN_HZ) s_in.xtal = XTAL_MIN_HZ;
    if (crystal_hz > XTAL_MAX_HZ) s_in.xtal = XTAL_MAX_HZ;
    s_in.rem = {16'd0, VCO_MAX_HZ};
  end

  // Work of the stage fed by pipe[k]: one quotient bit, the VCO product,
  // the fraction scaling, or the final P1/P2 assembly.
  function automatic pl_t stage_fn(input int k, input pl_t s);
    pl_t         o;
    logic [45:0] d;
    logic [37:0] prod;
    logic [9:0]  dve;
    logic [26:0] x;
    logic [6:0]  q0;
    logic [20:0] r;
    logic [7:0]  fr;
    begin
      o = s;
      if (k <= 9) begin
        d = {18'd0, s.f} << (9 - k);
        if (s.rem >= d) begin
          o.rem       = s.rem - d;
          o.dv[9 - k] = 1'b1;
        end
      end else if (k == 10) begin
        dve   = {s.dv[9:1], 1'b0};
        prod  = dve * s.f;
        o.dv  = dve;
        o.rem = {8'd0, prod};
      end else if (k <= 17) begin
        d = {20'd0, s.xtal} << (17 - k);
        if (s.rem >= d) begin
          o.rem        = s.rem - d;
          o.mq[17 - k] = 1'b1;
        end
      end else if (k == 18) begin
        o.rem = (s.rem << 20) - s.rem;
      end else if (k <= 38) begin
        d = {20'd0, s.xtal} << (38 - k);
        if (s.rem >= d) begin
          o.rem        = s.rem - d;
          o.nq[38 - k] = 1'b1;
        end
      end else begin
        // Divide num*128 by 2^20-1: high part plus wrapped-around correction.
        x  = {s.nq, 7'd0};
        q0 = x[26:20];
        r  = {1'b0, x[19:0]} + {14'd0, q0};
        if (r >= {1'b0, FRAC_DEN}) begin
          fr   = {1'b0, q0} + 8'd1;
          o.p2 = 20'(r - {1'b0, FRAC_DEN});
        end else begin
          fr   = {1'b0, q0};
          o.p2 = r[19:0];
        end
        o.p1 = {4'd0, s.mq, 7'd0} + {10'd0, fr} - P1_OFFSET;
      end
      return o;
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0] <= s_in;
    end
  end

  for (genvar k = 0; k < PIPE_LAST; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k + 1] <= 1'b0;
      end else if (en) begin
        vld[k + 1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pipe[k + 1] <= stage_fn(k, pipe[k]);
      end
    end
  end

  assign item.p1    = pipe[PIPE_LAST].p1;
  assign item.p2    = pipe[PIPE_LAST].p2;
  assign item.dp1   = {1'b0, pipe[PIPE_LAST].dv, 7'd0} - P1_OFFSET;
  assign item.ch    = pipe[PIPE_LAST].ch;
  assign item.clamp = pipe[PIPE_LAST].clamp;

  csrp_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .item_vld   (vld[PIPE_LAST]),
    .item       (item),
    .item_take  (item_take),
    .cfg        (cfg),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .reg_addr   (reg_addr),
    .wr_data    (wr_data),
    .last_write (last_write),
    .clamped    (clamped)
  );

endmodule

@@ test/csrp_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// csrp_checker
// Watches the request, write and configuration ports of the clock register
// planner, predicts the register write run of every request and compares.
// ----------------------------------------------------------------------------
module csrp_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [27:0] target_hz,
  input  logic [1:0]  channel,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [25:0] cfg_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  reg_addr,
  input  logic [7:0]  wr_data,
  input  logic        last_write,
  input  logic        clamped,
  output int          fail_count,
  output int          pending
);
  import csrp_pkg::*;

  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] data;
    logic       last;
    logic       clamp;
  } reg_write_t;

  reg_write_t  expected_writes[$];
  logic [25:0] crystal;
  cfg_t        regs;
  int          fails = 0;

  assign fail_count = fails;

  function automatic logic [7:0] block_byte(input int sel, input logic [31:0] p1,
                                            input logic [31:0] p2, input logic [31:0] p3);
    case (sel)
      0: return p3[15:8];
      1: return p3[7:0];
      2: return {6'd0, p1[17:16]};
      3: return p1[15:8];
      4: return p1[7:0];
      5: return {p3[19:16], p2[19:16]};
      6: return p2[15:8];
      default: return p2[7:0];
    endcase
  endfunction

  task automatic push_write(input logic [7:0] addr, input logic [7:0] data,
                            input logic last, input logic clamp);
    reg_write_t w;
    w.addr  = addr;
    w.data  = data;
    w.last  = last;
    w.clamp = clamp;
    expected_writes.push_back(w);
  endtask

  task automatic plan_writes(input logic [27:0] f_in, input logic [1:0] ch);
    logic [63:0] f, xtal, dv, vco, mult, rem, num, fr;
    logic [31:0] p1, p2;
    logic        clamp;
    logic [7:0]  base, b;
    int          i;
    f     = 64'(f_in);
    clamp = 1'b0;
    if (f < 64'd1000000) begin
      f = 64'd1000000;
      clamp = 1'b1;
    end
    if (f > 64'd225000000) begin
      f = 64'd225000000;
      clamp = 1'b1;
    end
    xtal = 64'(crystal);
    if (xtal < 64'd10000000) xtal = 64'd10000000;
    if (xtal > 64'd40000000) xtal = 64'd40000000;
    dv   = (64'd900000000 / f) & ~64'd1;
    vco  = dv * f;
    mult = vco / xtal;
    rem  = vco % xtal;
    num  = (rem * 64'd1048575) / xtal;
    fr   = (num * 64'd128) / 64'd1048575;
    p1   = 32'(128 * mult + fr - 512);
    p2   = 32'(128 * num - 64'd1048575 * fr);
    for (i = 0; i < 8; i++)
      push_write(regs.pll_base + 8'(i), block_byte(i, p1, p2, 32'd1048575),
                 (ch == CH_PLL_ONLY) && (i == 7), clamp);
    if (ch != CH_PLL_ONLY) begin
      base = (ch == 2'd0) ? regs.syn0_base : (ch == 2'd1) ? regs.syn1_base : regs.syn2_base;
      p1 = 32'(128 * dv - 512);
      for (i = 0; i < 8; i++) begin
        b = block_byte(i, p1, 32'd0, 32'd1);
        if (i == 2) b = b | {1'b0, regs.out_div};
        push_write(base + 8'(i), b, 1'b0, clamp);
      end
      push_write(regs.pll_rst, PLL_RESET_CMD, 1'b0, clamp);
      push_write(regs.ctrl_base + {6'd0, ch}, CLK_ON_PLLA, 1'b1, clamp);
    end
  endtask

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("ERROR at %0t: %s got 0x%02h, want 0x%02h", $realtime, what, got, want);
    fails++;
  endtask

  always @(posedge clk) begin
    reg_write_t w;
    if (rst) begin
      crystal        = 26'd25000000;
      regs.pll_base  = 8'd26;
      regs.syn0_base = 8'd42;
      regs.syn1_base = 8'd50;
      regs.syn2_base = 8'd58;
      regs.pll_rst   = 8'd177;
      regs.ctrl_base = 8'd16;
      regs.out_div   = 7'd0;
      expected_writes.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CRYSTAL:   crystal        = cfg_data;
          REG_PLL_BASE:  regs.pll_base  = cfg_data[7:0];
          REG_SYN0_BASE: regs.syn0_base = cfg_data[7:0];
          REG_SYN1_BASE: regs.syn1_base = cfg_data[7:0];
          REG_SYN2_BASE: regs.syn2_base = cfg_data[7:0];
          REG_PLL_RST:   regs.pll_rst   = cfg_data[7:0];
          REG_CTRL_BASE: regs.ctrl_base = cfg_data[7:0];
          REG_OUT_DIV:   regs.out_div   = cfg_data[6:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) plan_writes(target_hz, channel);
      if (out_valid && !out_stall) begin
        if (expected_writes.size() == 0) begin
          report("unexpected write, addr", reg_addr, 8'd0);
        end else begin
          w = expected_writes.pop_front();
          if (reg_addr !== w.addr) report("reg_addr", reg_addr, w.addr);
          if (wr_data !== w.data) report("wr_data", wr_data, w.data);
          if (last_write !== w.last) report("last_write", 8'(last_write), 8'(w.last));
          if (clamped !== w.clamp) report("clamped", 8'(clamped), 8'(w.clamp));
        end
      end
    end
    pending = expected_writes.size();
  end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives frequency requests and register settings into the clock register
// planner under random idling and back-pressure; the checker judges writes.
// ----------------------------------------------------------------------------
module tb_top;
  import csrp_pkg::*;

  localparam int STALL_LIMIT = 4000;  // cycles without any transfer
  localparam int DRAIN_WAIT  = 60;    // covers the pipeline depth

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [27:0] target_hz;
  logic [1:0]  channel;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [25:0] cfg_data;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  reg_addr;
  logic [7:0]  wr_data;
  logic        last_write;
  logic        clamped;
  int          fail_count;
  int          pending;

  // Knobs shared between the sender and the receiver, and the watchdog count.
  bit idling = 1'b1;
  bit hold_req = 1'b0;
  int quiet_cycles = 0;

  clock_synth_register_planner u_top (.*);

  csrp_checker u_checker (.*);

  // Clock; the single reset at the start is driven by the stimulus.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: draw a stall length per write, and honor one long hold-off so
  // the pipeline fills and the request side backs up.
  initial begin
    int n;
    out_stall = 1'b1;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
      end
      n = idling ? $urandom_range(0, 16) : 0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      // hold low until one write transfer completes
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Write one configuration register at the next falling edge.
  task automatic write_reg(input logic [2:0] idx, input logic [25:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  task automatic write_all(input logic [25:0] xtal, input logic [7:0] pll_b,
                           input logic [7:0] s0, input logic [7:0] s1,
                           input logic [7:0] s2, input logic [7:0] rst_a,
                           input logic [7:0] ctrl, input logic [6:0] odiv);
    write_reg(REG_CRYSTAL, xtal);
    write_reg(REG_PLL_BASE, {18'd0, pll_b});
    write_reg(REG_SYN0_BASE, {18'd0, s0});
    write_reg(REG_SYN1_BASE, {18'd0, s1});
    write_reg(REG_SYN2_BASE, {18'd0, s2});
    write_reg(REG_PLL_RST, {18'd0, rst_a});
    write_reg(REG_CTRL_BASE, {18'd0, ctrl});
    write_reg(REG_OUT_DIV, {19'd0, odiv});
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Wait until every predicted write came out, then let the pipeline settle.
  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // Offer one request and hold it until the transfer.
  task automatic send_request(input logic [27:0] f, input logic [1:0] ch);
    int gap;
    gap = idling ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    target_hz <= f;
    channel   <= ch;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic random_requests(input int count);
    logic [27:0] f;
    int k;
    for (k = 0; k < count; k++) begin
      case ($urandom_range(0, 9))
        0: f = 28'($urandom);                          // any 28-bit value
        1: f = 28'($urandom_range(0, 1000000));
        2: f = 28'($urandom_range(150000000, 28'hFFFFFFF));
        default: f = 28'($urandom_range(1000000, 225000000));
      endcase
      // now and then, pause until the planner has emptied
      if ($urandom_range(0, 19) == 0) begin
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
      end
      send_request(f, 2'($urandom_range(0, 3)));
    end
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_config();
    write_all(26'($urandom_range(10000000, 40000000)), 8'($urandom), 8'($urandom),
              8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              7'($urandom_range(0, 112)));
  endtask

  // Stimulus: directed corners under reset defaults, then random phases.
  initial begin
    int c;
    rst       = 1'b1;
    in_valid  = 1'b0;
    target_hz = '0;
    channel   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (6) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Frequency corners, clamping both ways, every channel.
    for (c = 0; c < 4; c++) begin
      send_request(28'd0, 2'(c));
      send_request(28'd225000000, 2'(c));
      send_request(28'd1000000, 2'(c));
    end
    send_request(28'd999999, 2'd0);
    send_request(28'd225000001, 2'd1);
    send_request(28'hFFFFFFF, 2'd2);
    send_request(28'd1, CH_PLL_ONLY);
    send_request(28'd10000000, 2'd1);
    send_request(28'd112500000, 2'd2);
    send_request(28'd27000000, 2'd0);
    send_request(28'd150000000, CH_PLL_ONLY);
    in_valid <= 1'b0;
    @(negedge clk);
    drain();

    // Low extremes, with the long receiver hold-off.
    write_all(26'd10000000, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 7'd0);
    hold_req = 1'b1;
    random_requests(30);
    drain();

    // High extremes: address wrap past 255; pause the sender mid-phase.
    write_all(26'd40000000, 8'd255, 8'd255, 8'd250, 8'd249, 8'd255, 8'd255, 7'd112);
    random_requests(15);
    while (pending != 0) @(negedge clk);
    random_requests(15);
    drain();

    // Crystal outside the supported range on both sides.
    write_all(26'd5000000, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom), 8'($urandom), 7'd127);
    random_requests(15);
    drain();
    write_all(26'h3FFFFFF, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom), 8'($urandom), 7'd85);
    random_requests(15);
    drain();

    // Random settings; one phase runs at full rate with no idling.
    random_config();
    idling = 1'b0;
    random_requests(30);
    drain();
    idling = 1'b1;
    random_config();
    random_requests(30);
    drain();
    random_config();
    random_requests(30);
    drain();

    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
